// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the deque bank modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define WSDB_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define WSDB_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wsdb_pkg.sv -----
// Package for the work-stealing deque bank: types, codes and constants
package wsdb_pkg;

  localparam int MAX_LANES   = 8;
  localparam int LANE_W      = 3;
  localparam int CNT_W       = 4;
  localparam int HANDLE_BITS = 16;
  localparam int RING_SLOTS_DEF = 64;

  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD   = 64'd1442695040888963407;
  localparam logic [63:0] SEED_BASE = 64'h9e3779b97f4a7c15;
  localparam int          SEED_SHIFT = 33;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_STEAL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL0, S_MUL1, S_MUL2, S_ADD, S_MOD, S_SCAN, S_READ, S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;
    logic use_victim;
    logic push;
    logic pop;
    logic set_bad;
    logic set_empty;
    logic set_full;
    logic mul_first;
    logic mul_hi_b;
    logic mul_hi_a;
    logic add_c;
    logic mod_step;
    logic scan_step;
    logic steal_take;
    logic cap_read;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       bad;
    logic       full;
    logic       empty;
    logic       few;
    logic       mod_last;
    logic       hit;
    logic       scan_last;
    logic       out_free;
  } sts_t;

endpackage

// ----- rtl/work_stealing_deque_bank.sv -----
// Work-stealing deque bank: one item at a time, controller plus datapath.
// Push and commands refused at decode pass through decode and finish, pop also through
// a ring read; a steal forms three 32x32 partial products through one shared multiplier,
// adds the LCG increment, runs a 4-bit-per-cycle modulo by the lane count, then scans
// the lanes one at a time and does a ring memory read.
// The result waits in an output register, and the next item is taken once the
// controller is back at rest.
module work_stealing_deque_bank #(
  parameter int RING_SLOTS = wsdb_pkg::RING_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [wsdb_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [wsdb_pkg::LANE_W-1:0]       in_lane,
  input  logic [wsdb_pkg::HANDLE_BITS-1:0]  in_task_handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wsdb_pkg::HANDLE_BITS-1:0]  out_task_out,
  output logic [wsdb_pkg::LANE_W-1:0]       out_source_lane,
  output logic [1:0]                        out_status
);

  wsdb_pkg::cmd_t cmd;
  wsdb_pkg::sts_t sts;

  // Sequence the commands
  wsdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the deques and do the arithmetic
  wsdb_dp #(.RING_SLOTS(RING_SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_lane         (in_lane),
    .in_task_handle  (in_task_handle),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_task_out    (out_task_out),
    .out_source_lane (out_source_lane),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ----- rtl/wsdb_ctrl.sv -----
// Controller state machine of the deque bank
`include "assert_macros.svh"

module wsdb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  wsdb_pkg::sts_t sts,
  output wsdb_pkg::cmd_t cmd
);

  wsdb_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsdb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance state and issue commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      wsdb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = wsdb_pkg::S_DECODE;
        end
      end
      wsdb_pkg::S_DECODE: begin
        state_nxt = wsdb_pkg::S_FINISH;
        if (sts.bad) begin
          cmd.set_bad = 1'b1;
        end else begin
          case (sts.cmd)
            wsdb_pkg::CMD_PUSH: begin
              if (sts.full) cmd.set_full = 1'b1;
              else          cmd.push     = 1'b1;
            end
            wsdb_pkg::CMD_POP: begin
              if (sts.empty) begin
                cmd.set_empty = 1'b1;
              end else begin
                cmd.pop   = 1'b1;
                state_nxt = wsdb_pkg::S_READ;
              end
            end
            wsdb_pkg::CMD_STEAL: begin
              if (sts.few) cmd.set_empty = 1'b1;
              else         state_nxt     = wsdb_pkg::S_MUL0;
            end
            default: cmd.set_empty = 1'b1;
          endcase
        end
      end
      wsdb_pkg::S_MUL0: begin
        cmd.mul_first = 1'b1;
        state_nxt     = wsdb_pkg::S_MUL1;
      end
      wsdb_pkg::S_MUL1: begin
        cmd.mul_hi_b = 1'b1;
        state_nxt    = wsdb_pkg::S_MUL2;
      end
      wsdb_pkg::S_MUL2: begin
        cmd.mul_hi_a = 1'b1;
        state_nxt    = wsdb_pkg::S_ADD;
      end
      wsdb_pkg::S_ADD: begin
        cmd.add_c = 1'b1;
        state_nxt = wsdb_pkg::S_MOD;
      end
      wsdb_pkg::S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = wsdb_pkg::S_SCAN;
      end
      wsdb_pkg::S_SCAN: begin
        cmd.use_victim = 1'b1;
        if (sts.hit) begin
          cmd.steal_take = 1'b1;
          state_nxt      = wsdb_pkg::S_READ;
        end else if (sts.scan_last) begin
          cmd.set_empty = 1'b1;
          state_nxt     = wsdb_pkg::S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      wsdb_pkg::S_READ: begin
        cmd.cap_read = 1'b1;
        state_nxt    = wsdb_pkg::S_FINISH;
      end
      wsdb_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = wsdb_pkg::S_IDLE;
        end
      end
      default: state_nxt = wsdb_pkg::S_IDLE;
    endcase
  end

  `WSDB_ASSERT_SAME(a_emit_free, cmd.emit, sts.out_free, "result emitted over a waiting item")
  `WSDB_ASSERT_NEXT(a_take_decode, cmd.take_in, state_r == wsdb_pkg::S_DECODE, "item not decoded")
  `WSDB_ASSERT_NEXT(a_pop_read, cmd.pop || cmd.steal_take, state_r == wsdb_pkg::S_READ,
                    "ring read not captured")

endmodule

// ----- rtl/wsdb_dp.sv -----
// Datapath of the deque bank: counters, seeds, ring memory, LCG and scan
`include "assert_macros.svh"

module wsdb_dp #(
  parameter int RING_SLOTS = wsdb_pkg::RING_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [wsdb_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic [1:0]                        in_cmd,
  input  logic [wsdb_pkg::LANE_W-1:0]       in_lane,
  input  logic [wsdb_pkg::HANDLE_BITS-1:0]  in_task_handle,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [wsdb_pkg::HANDLE_BITS-1:0]  out_task_out,
  output logic [wsdb_pkg::LANE_W-1:0]       out_source_lane,
  output logic [1:0]                        out_status,
  input  wsdb_pkg::cmd_t                    cmd,
  output wsdb_pkg::sts_t                    sts
);

  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int CTR_W  = SLOT_W + 1;
  localparam int LANES  = wsdb_pkg::MAX_LANES;
  localparam int LW     = wsdb_pkg::LANE_W;
  localparam int HW     = wsdb_pkg::HANDLE_BITS;
  localparam int DEPTH  = LANES * RING_SLOTS;

  logic [wsdb_pkg::CNT_W-1:0] cfg_r;
  logic [1:0]    cmd_r;
  logic [LW-1:0] lane_r;
  logic [HW-1:0] hdl_r;
  logic [CTR_W-1:0] top_r [LANES];
  logic [CTR_W-1:0] bot_r [LANES];
  logic [63:0]   seed_r [LANES];
  logic [HW-1:0] ring_mem [DEPTH];
  logic [HW-1:0] rdata_r;
  logic [63:0]   acc_r;
  logic [31:0]   modq_r;
  logic [2:0]    rem_r;
  logic [2:0]    modcnt_r;
  logic [LW-1:0] vic_r;
  logic [LW-1:0] step_r;
  logic [HW-1:0] res_task_r;
  logic [LW-1:0] res_src_r;
  logic [1:0]    res_st_r;
  logic          out_valid_r;
  logic [HW-1:0] out_task_r;
  logic [LW-1:0] out_src_r;
  logic [1:0]    out_st_r;

  logic [wsdb_pkg::CNT_W-1:0] count;
  logic [LW-1:0]    idx;
  logic [CTR_W-1:0] top_sel, bot_sel, fill_sel, bot_dec;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod, seed_new;
  logic [2:0]       rem_nxt;
  logic [3:0]       rem_t;
  logic [LW:0]      vic_inc;
  logic             mem_we, mem_re;
  logic [LW+SLOT_W-1:0] waddr, raddr;

  // Clamp the lane count and pick the lane under inspection
  assign count    = (cfg_r > wsdb_pkg::CNT_W'(LANES)) ? wsdb_pkg::CNT_W'(LANES) : cfg_r;
  assign idx      = cmd.use_victim ? vic_r : lane_r;
  assign top_sel  = top_r[idx];
  assign bot_sel  = bot_r[idx];
  assign fill_sel = bot_sel - top_sel;
  assign bot_dec  = bot_sel - CTR_W'(1);

  assign sts.cmd       = cmd_r;
  assign sts.bad       = {1'b0, lane_r} >= count;
  assign sts.full      = fill_sel[CTR_W-1];
  assign sts.empty     = (fill_sel == '0);
  assign sts.few       = count < wsdb_pkg::CNT_W'(2);
  assign sts.mod_last  = (modcnt_r == 3'd7);
  assign sts.hit       = (vic_r != lane_r) && (fill_sel != '0);
  assign sts.scan_last = ({1'b0, step_r} == count - wsdb_pkg::CNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  // Share one 32x32 multiplier over the partial products
  assign mul_a    = cmd.mul_hi_a ? seed_r[lane_r][63:32] : seed_r[lane_r][31:0];
  assign mul_b    = cmd.mul_hi_b ? wsdb_pkg::LCG_MUL[63:32] : wsdb_pkg::LCG_MUL[31:0];
  assign prod     = mul_a * mul_b;
  assign seed_new = acc_r + wsdb_pkg::LCG_ADD;

  // Reduce four quotient bits a cycle modulo the lane count
  always_comb begin
    rem_nxt = rem_r;
    rem_t   = '0;
    for (int i = 0; i < 4; i++) begin
      rem_t = {rem_nxt, modq_r[31-i]};
      if (rem_t >= count) rem_t = rem_t - count;
      rem_nxt = rem_t[2:0];
    end
  end

  assign vic_inc = {1'b0, vic_r} + (LW+1)'(1);
  assign mem_we  = cmd.push;
  assign mem_re  = cmd.pop || cmd.steal_take;
  assign waddr   = {lane_r, bot_sel[SLOT_W-1:0]};
  assign raddr   = cmd.pop ? {lane_r, bot_dec[SLOT_W-1:0]} : {vic_r, top_sel[SLOT_W-1:0]};

  // Ring memory
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[waddr] <= hdl_r;
    if (mem_re) rdata_r <= ring_mem[raddr];
  end

  // Hold configuration, counters and seeds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      for (int i = 0; i < LANES; i++) begin
        top_r[i]  <= '0;
        bot_r[i]  <= '0;
        seed_r[i] <= wsdb_pkg::SEED_BASE * 64'(i + 1);
      end
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (cmd.push)       bot_r[lane_r] <= bot_sel + CTR_W'(1);
      if (cmd.pop)        bot_r[lane_r] <= bot_dec;
      if (cmd.steal_take) top_r[vic_r]  <= top_sel + CTR_W'(1);
      if (cmd.add_c)      seed_r[lane_r] <= seed_new;
    end
  end

  // Latch the item and run the steal arithmetic and scan
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cmd_r  <= in_cmd;
      lane_r <= in_lane;
      hdl_r  <= in_task_handle;
    end
    if (cmd.mul_first) acc_r <= prod;
    else if (cmd.mul_hi_a || cmd.mul_hi_b) acc_r <= acc_r + {prod[31:0], 32'd0};
    if (cmd.add_c) begin
      modq_r   <= {1'b0, seed_new[63:wsdb_pkg::SEED_SHIFT]};
      rem_r    <= '0;
      modcnt_r <= '0;
    end
    if (cmd.mod_step) begin
      modq_r   <= {modq_r[27:0], 4'd0};
      rem_r    <= rem_nxt;
      modcnt_r <= modcnt_r + 3'd1;
      vic_r    <= rem_nxt;
      step_r   <= '0;
    end
    if (cmd.scan_step) begin
      vic_r  <= (vic_inc == (LW+1)'(count)) ? '0 : vic_inc[LW-1:0];
      step_r <= step_r + LW'(1);
    end
    if (cmd.set_bad || cmd.set_empty || cmd.set_full || cmd.push) begin
      res_task_r <= '0;
      res_src_r  <= '0;
    end
    if (cmd.set_bad)   res_st_r <= wsdb_pkg::ST_BAD;
    if (cmd.set_empty) res_st_r <= wsdb_pkg::ST_EMPTY;
    if (cmd.set_full)  res_st_r <= wsdb_pkg::ST_FULL;
    if (cmd.push)      res_st_r <= wsdb_pkg::ST_OK;
    if (cmd.pop) begin
      res_src_r <= lane_r;
      res_st_r  <= wsdb_pkg::ST_OK;
    end
    if (cmd.steal_take) begin
      res_src_r <= vic_r;
      res_st_r  <= wsdb_pkg::ST_OK;
    end
    if (cmd.cap_read) res_task_r <= rdata_r;
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_task_r <= res_task_r;
      out_src_r  <= res_src_r;
      out_st_r   <= res_st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_task_out    = out_task_r;
  assign out_source_lane = out_src_r;
  assign out_status      = out_st_r;

  `WSDB_ASSERT_SAME(a_fail_zero, out_valid_r && out_st_r != wsdb_pkg::ST_OK,
                    out_task_r == '0 && out_src_r == '0, "failed item carries data")
  `WSDB_ASSERT_SAME(a_fill_bound, cmd.push || cmd.pop || cmd.steal_take,
                    fill_sel <= CTR_W'(RING_SLOTS), "ring overfilled")
  `WSDB_ASSERT_SAME(a_steal_victim, cmd.steal_take, vic_r != lane_r, "stole from requester")

endmodule

// ----- bench/deque_bank_checker.sv -----
// Checker for the deque bank: shadow model of the lanes and comparison of every result
module deque_bank_checker
  import wsdb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic [LANE_W-1:0]      in_lane,
  input  logic [HANDLE_BITS-1:0] in_task_handle,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [HANDLE_BITS-1:0] out_task_out,
  input  logic [LANE_W-1:0]      out_source_lane,
  input  logic [1:0]             out_status,
  output int                     fail_count,
  output int                     pending
);
  localparam int SLOTS = RING_SLOTS_DEF;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] task_h;
    logic [LANE_W-1:0]      src;
    logic [1:0]             status;
  } deque_result_t;

  deque_result_t   awaited_results[$];
  logic [3:0]      shadow_lanes;
  logic [6:0]      shadow_top [MAX_LANES];
  logic [6:0]      shadow_bot [MAX_LANES];
  logic [15:0]     shadow_ring [MAX_LANES][SLOTS];
  logic [63:0]     shadow_seed [MAX_LANES];

  function automatic int lane_fill(int l);
    logic [6:0] f;
    f = shadow_bot[l] - shadow_top[l];
    return int'(f);
  endfunction

  // Apply one command to the shadow deques and give its result
  function automatic deque_result_t apply_command(logic [1:0] cmd, int l,
                                                  logic [15:0] h);
    deque_result_t r;
    int cnt;
    int start;
    int v;
    r = '{task_h: '0, src: '0, status: ST_EMPTY};
    cnt = (shadow_lanes > MAX_LANES) ? MAX_LANES : int'(shadow_lanes);
    if (l >= cnt) begin
      r.status = ST_BAD;
    end else if (cmd == CMD_PUSH) begin
      if (lane_fill(l) >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        shadow_ring[l][shadow_bot[l][5:0]] = h;
        shadow_bot[l] = shadow_bot[l] + 7'd1;
        r.status = ST_OK;
      end
    end else if (cmd == CMD_POP) begin
      if (lane_fill(l) != 0) begin
        shadow_bot[l] = shadow_bot[l] - 7'd1;
        r = '{task_h: shadow_ring[l][shadow_bot[l][5:0]], src: LANE_W'(l), status: ST_OK};
      end
    end else if (cmd == CMD_STEAL && cnt >= 2) begin
      shadow_seed[l] = shadow_seed[l] * LCG_MUL + LCG_ADD;
      start = int'((shadow_seed[l] >> SEED_SHIFT) % 64'(cnt));
      for (int s = 0; s < cnt; s++) begin
        v = (start + s) % cnt;
        if (v != l && lane_fill(v) != 0 && r.status != ST_OK) begin
          r = '{task_h: shadow_ring[v][shadow_top[v][5:0]], src: LANE_W'(v), status: ST_OK};
          shadow_top[v] = shadow_top[v] + 7'd1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Track configuration, predict on each accepted item, compare each result
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      awaited_results.delete();
      shadow_lanes <= '0;
      fail_count = 0;
      for (int i = 0; i < MAX_LANES; i++) begin
        shadow_top[i] = '0;
        shadow_bot[i] = '0;
        shadow_seed[i] = SEED_BASE * 64'(i + 1);
      end
    end else begin
      if (cfg_wr_en) shadow_lanes <= cfg_wr_data;
      if (in_valid && in_ready)
        awaited_results.push_back(apply_command(in_cmd, int'(in_lane), in_task_handle));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status != want.status)
            report_mismatch("status", out_status, want.status);
          if (out_task_out != want.task_h)
            report_mismatch("task_out", out_task_out, want.task_h);
          if (out_source_lane != want.src)
            report_mismatch("source_lane", out_source_lane, want.src);
        end
      end
    end
    pending = awaited_results.size();
  end
endmodule

// ----- bench/tb_top.sv -----
// Top of the deque bank testbench: stimulus, idling, watchdog and verdict
module tb_top;
  import wsdb_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_cmd = CMD_PUSH;
  logic [LANE_W-1:0]      in_lane = '0;
  logic [HANDLE_BITS-1:0] in_task_handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [HANDLE_BITS-1:0] out_task_out;
  logic [LANE_W-1:0]      out_source_lane;
  logic [1:0]             out_status;
  int                     fail_count;
  int                     pending;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  bit                     recv_hold = 1'b0;
  int                     quiet_cycles = 0;
  int                     sent_items = 0;
  int                     lane_counts_used [int];
  logic [15:0]            next_handle = 16'h1;

  always #2 clk = ~clk;

  work_stealing_deque_bank i_dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_ready, .in_cmd, .in_lane, .in_task_handle,
    .out_valid, .out_ready, .out_task_out, .out_source_lane, .out_status
  );

  deque_bank_checker i_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_ready, .in_cmd, .in_lane, .in_task_handle,
    .out_valid, .out_ready, .out_task_out, .out_source_lane, .out_status,
    .fail_count, .pending
  );

  // Receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run after a long stretch with no item moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("** work_stealing_deque_bank: FAILED **");
      $finish;
    end
  end

  // Offer one item and hold it until taken
  task automatic send_item(logic [1:0] cmd, logic [LANE_W-1:0] l, logic [15:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_lane <= l;
    in_task_handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  // Stop offering, wait for every result, then for the block to come back to rest
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_lanes(logic [CNT_W-1:0] n);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lane_counts_used[int'(n)] = 1;
  endtask

  // Random command mix: mostly pushes and steals, some pops and odd codes
  task automatic random_items(int n, int lanes);
    int roll;
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      cmd = roll < 42 ? CMD_PUSH : roll < 70 ? CMD_STEAL : roll < 96 ? CMD_POP : 2'd3;
      send_item(cmd,
                (roll % 9 == 0) ? LANE_W'($urandom) : LANE_W'($urandom_range(lanes - 1)),
                16'($urandom));
    end
  endtask

  initial begin
    int plan [6];
    plan = '{8, 3, 1, 5, 2, 8};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no lanes yet, so the first two commands are refused
    send_item(CMD_PUSH, 3'd0, 16'hFFFF);
    send_item(CMD_STEAL, 3'd7, 16'h0);
    set_lanes(4'd8);
    send_item(CMD_POP, 3'd2, 16'h0);
    send_item(CMD_STEAL, 3'd2, 16'h0);
    send_item(2'd3, 3'd1, 16'h0);
    send_item(CMD_PUSH, 3'd7, 16'hFFFF);
    send_item(CMD_PUSH, 3'd0, 16'h0000);
    send_item(CMD_PUSH, 3'd0, 16'hA5A5);
    send_item(CMD_POP, 3'd7, 16'h0);
    send_item(CMD_STEAL, 3'd7, 16'h0);
    send_item(CMD_STEAL, 3'd3, 16'h0);
    // Fill lane 5 past capacity so the last two pushes are refused
    for (int i = 0; i < 66; i++) send_item(CMD_PUSH, 3'd5, 16'(i * 997));
    set_lanes(4'd15);
    send_item(CMD_STEAL, 3'd1, 16'h0);
    set_lanes(4'd1);
    send_item(CMD_STEAL, 3'd0, 16'h0);
    send_item(CMD_POP, 3'd0, 16'h0);

    // Long receiver hold while items keep coming, then a full pause
    set_lanes(4'd8);
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
      random_items(12, 8);
    join
    drain();

    // Random phases through several lane counts and idling patterns
    foreach (plan[p]) begin
      set_lanes(4'(plan[p]));
      send_idle_pct = p < 2 ? 32 : p < 4 ? 75 : 0;
      recv_idle_pct = p < 2 ? 75 : p < 4 ? 32 : 0;
      random_items(260, plan[p]);
    end
    set_lanes(4'd0);
    random_items(20, 1);
    drain();

    $display("ran %0d items over %0d lane settings, idling on both channels",
             sent_items, lane_counts_used.num());
    if (fail_count == 0) begin
      $display("** work_stealing_deque_bank: PASSED **");
    end else begin
      $display("** work_stealing_deque_bank: FAILED **");
    end
    $finish;
  end
endmodule

// ----- work_stealing_deque_bank.f -----
+incdir+rtl
rtl/wsdb_pkg.sv
rtl/wsdb_ctrl.sv
rtl/wsdb_dp.sv
rtl/work_stealing_deque_bank.sv
bench/deque_bank_checker.sv
bench/tb_top.sv
